@@ rtl/core/rrq_pkg.sv @@
// Shared constants, command codes and control struct for the round-robin ready queue.
`timescale 1ns / 1ps

package rrq_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 8;
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

	// Field widths of the beats on the two channels.
	localparam int CMD_BITS = 2;
	localparam int OCC_BITS = 5;

	// Command codes; the fourth code carries no operation.
	typedef enum logic [CMD_BITS-1:0] {
		CMD_ADMIT  = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_NEXT   = 2'd2
	} rrq_cmd_t;

	// Per-cycle control broadcast from the top level to every cell.
	typedef struct packed {
		logic                admit;
		logic                remove;
		logic                rotate;
		logic [ID_BITS-1:0]  id;
		logic [CNT_BITS-1:0] count;
	} rrq_ctrl_t;

endpackage

@@ rtl/core/rrq_cmd_if.sv @@
// Command channel: valid/ready handshake with command and thread id payload.
`timescale 1ns / 1ps

interface rrq_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [rrq_pkg::CMD_BITS-1:0] command;
	logic [7:0]                   thread_id;

	modport source (output valid, output command, output thread_id, input ready);
	modport sink (input valid, input command, input thread_id, output ready);
endinterface

@@ rtl/core/rrq_res_if.sv @@
// Result channel: valid/ready handshake with returned id, status and occupancy.
`timescale 1ns / 1ps

interface rrq_res_if;
	logic                         valid;
	logic                         ready;
	logic [7:0]                   result_id;
	logic                         ok;
	logic [rrq_pkg::OCC_BITS-1:0] occupancy;

	modport source (output valid, output result_id, output ok, output occupancy, input ready);
	modport sink (input valid, input result_id, input ok, input occupancy, output ready);
endinterface

@@ rtl/core/rrq_cell.sv @@
// One queue slot: holds an id, compares it, and shifts from its neighbor.
`timescale 1ns / 1ps

module rrq_cell (
	input  logic                         clk,
	input  logic [rrq_pkg::IDX_BITS-1:0] index,
	input  rrq_pkg::rrq_ctrl_t           ctrl,
	input  logic [rrq_pkg::ID_BITS-1:0]  upper_data,
	input  logic [rrq_pkg::ID_BITS-1:0]  head_data,
	input  logic                         hit_in,
	output logic                         hit_out,
	output logic [rrq_pkg::ID_BITS-1:0]  data
);

	logic [rrq_pkg::ID_BITS-1:0]  data_q;
	logic [rrq_pkg::CNT_BITS-1:0] pos;
	logic [rrq_pkg::CNT_BITS-1:0] pos_plus;
	logic                         valid;
	logic                         has_upper;
	logic                         is_tail;
	logic                         is_free;
	logic                         match;

	// Position of this slot relative to the fill level.
	assign pos       = (rrq_pkg::CNT_BITS)'(index);
	assign pos_plus  = pos + (rrq_pkg::CNT_BITS)'(1);
	assign valid     = pos < ctrl.count;
	assign has_upper = pos_plus < ctrl.count;
	assign is_tail   = pos_plus == ctrl.count;
	assign is_free   = pos == ctrl.count;

	// A hit in this slot or any slot nearer the head opens the gap here.
	assign match   = valid && (data_q == ctrl.id);
	assign hit_out = hit_in || match;
	assign data    = data_q;

	// Slot update: append, close the gap, or rotate the head to the tail.
	always_ff @(posedge clk) begin
		if (ctrl.admit && is_free) begin
			data_q <= ctrl.id;
		end else if (ctrl.remove && hit_out && has_upper) begin
			data_q <= upper_data;
		end else if (ctrl.rotate && has_upper) begin
			data_q <= upper_data;
		end else if (ctrl.rotate && is_tail) begin
			data_q <= head_data;
		end
	end

endmodule

@@ rtl/core/rrq_chain.sv @@
// Row of queue cells with the neighbor links and the first-match chain.
`timescale 1ns / 1ps

module rrq_chain (
	input  logic                        clk,
	input  rrq_pkg::rrq_ctrl_t          ctrl,
	output logic                        found,
	output logic [rrq_pkg::ID_BITS-1:0] head
);

	logic [rrq_pkg::ID_BITS-1:0] cell_data [rrq_pkg::QUEUE_DEPTH];
	logic [rrq_pkg::ID_BITS-1:0] upper    [rrq_pkg::QUEUE_DEPTH];
	logic [rrq_pkg::QUEUE_DEPTH:0] hit;

	assign hit[0] = 1'b0;
	assign found  = hit[rrq_pkg::QUEUE_DEPTH];
	assign head   = cell_data[0];

	// Each cell takes its upper neighbor's id; the last one has none in use.
	for (genvar i = 0; i < rrq_pkg::QUEUE_DEPTH; i++) begin : g_cell
		if (i == rrq_pkg::QUEUE_DEPTH - 1) begin : g_last
			assign upper[i] = ctrl.id;
		end else begin : g_mid
			assign upper[i] = cell_data[i+1];
		end

		rrq_cell u_cell (
			.clk        (clk),
			.index      ((rrq_pkg::IDX_BITS)'(i)),
			.ctrl       (ctrl),
			.upper_data (upper[i]),
			.head_data  (cell_data[0]),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.data       (cell_data[i])
		);
	end

endmodule

@@ rtl/core/round_robin_ready_queue.sv @@
// Top level of the round-robin ready queue: command decode, fill count, result register.
`timescale 1ns / 1ps

// Ordered queue of up to 16 thread ids held in a row of cells, head in the
// first cell. Each command beat (admit, remove, next) is executed in the cycle
// it is accepted, and its result beat appears registered in the cycle after; a
// new command is taken every cycle as long as the result register is empty or
// being drained, so the block sustains one command per clock. The cycle is set
// by the compare-and-shift row: every cell compares its id in parallel, a
// first-match chain runs across all 16 cells, and each cell loads from its
// neighbor in the same edge. Admit on a full queue and remove of an absent id
// leave the queue as it is and return ok low; next on an empty queue returns
// id zero with ok low. The unused command code changes nothing and returns
// id zero, ok low and the current occupancy.
module round_robin_ready_queue (
	input  logic      clk,
	input  logic      arst_n,
	rrq_cmd_if.sink   cmd,
	rrq_res_if.source res
);

	logic [rrq_pkg::CNT_BITS-1:0] count_q;
	logic                         res_valid_q;
	logic [rrq_pkg::ID_BITS-1:0]  res_id_q;
	logic                         res_ok_q;
	logic [rrq_pkg::OCC_BITS-1:0] res_occ_q;

	rrq_pkg::rrq_ctrl_t           ctrl;
	logic                         fire;
	logic                         full;
	logic                         empty;
	logic                         found;
	logic [rrq_pkg::ID_BITS-1:0]  head;
	logic [rrq_pkg::ID_BITS-1:0]  in_id;
	logic [rrq_pkg::CNT_BITS-1:0] count_d;
	logic [rrq_pkg::ID_BITS-1:0]  result_id_d;
	logic                         ok_d;

	// Accept a command whenever the result register is free or draining.
	assign cmd.ready = !res_valid_q || res.ready;
	assign fire      = cmd.valid && cmd.ready;

	assign in_id = cmd.thread_id[rrq_pkg::ID_BITS-1:0];
	assign full  = count_q == (rrq_pkg::CNT_BITS)'(rrq_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;

	// Decode the command into cell controls. A remove of an absent id finds no
	// match in the row, so no cell shifts.
	always_comb begin
		ctrl.admit  = 1'b0;
		ctrl.remove = 1'b0;
		ctrl.rotate = 1'b0;
		ctrl.id     = in_id;
		ctrl.count  = count_q;
		case (cmd.command)
			rrq_pkg::CMD_ADMIT: begin
				ctrl.admit = fire && !full;
			end
			rrq_pkg::CMD_REMOVE: begin
				ctrl.remove = fire;
			end
			rrq_pkg::CMD_NEXT: begin
				ctrl.rotate = fire && !empty;
			end
			default: begin
				ctrl.admit = 1'b0;
			end
		endcase
	end

	// Work out the new count and the result of the command.
	always_comb begin
		count_d     = count_q;
		result_id_d = '0;
		ok_d        = 1'b0;
		case (cmd.command)
			rrq_pkg::CMD_ADMIT: begin
				result_id_d = in_id;
				ok_d        = !full;
				if (!full) begin
					count_d = count_q + (rrq_pkg::CNT_BITS)'(1);
				end
			end
			rrq_pkg::CMD_REMOVE: begin
				result_id_d = in_id;
				ok_d        = found;
				if (found) begin
					count_d = count_q - (rrq_pkg::CNT_BITS)'(1);
				end
			end
			rrq_pkg::CMD_NEXT: begin
				ok_d = !empty;
				if (!empty) begin
					result_id_d = head;
				end
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	rrq_chain u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.found (found),
		.head  (head)
	);

	// Fill count and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_id_q  <= result_id_d;
			res_ok_q  <= ok_d;
			res_occ_q <= (rrq_pkg::OCC_BITS)'(count_d);
		end
	end

	assign res.valid     = res_valid_q;
	assign res.result_id = 8'(res_id_q);
	assign res.ok        = res_ok_q;
	assign res.occupancy = res_occ_q;

	// The fill level never passes the queue depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (rrq_pkg::CNT_BITS)'(rrq_pkg::QUEUE_DEPTH))
		else $error("queue count exceeds depth");

	// A pending result reports the count the queue holds now.
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_occ_q == (rrq_pkg::OCC_BITS)'(count_q)))
		else $error("reported occupancy differs from queue count");

	// A successful admit grows the queue by one.
	a_admit_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd.command == rrq_pkg::CMD_ADMIT && !full)
		|=> (count_q == $past(count_q) + (rrq_pkg::CNT_BITS)'(1)))
		else $error("admit did not grow the queue");

	// Rotation keeps the queue length.
	a_rotate_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd.command == rrq_pkg::CMD_NEXT) |=> $stable(count_q))
		else $error("next changed the queue length");

endmodule
